// ===== hw/rtl/vr3d_pkg.sv =====
// shared widths, constants and stage types of the 3d refraction core
`timescale 1ns / 1ps

package vr3d_pkg;

  // component and index formats
  localparam int COMP_BITS = 16;
  localparam int COMP_FRAC = 14;
  localparam int INDEX_W   = 16;

  // internal fixed point has WF fraction bits
  localparam int WF     = 30;
  localparam int OUT_SH = WF - COMP_FRAC;

  // ratio divider: one quotient bit per cell
  localparam int DIV_STEPS = INDEX_W + WF;
  localparam int R_W       = DIV_STEPS;
  localparam int R_SPLIT   = R_W / 2;

  // square root: one result bit per cell over a 62 bit radicand
  localparam int SQ_STEPS = 31;
  localparam int SQ_X_W   = 2 * SQ_STEPS;
  localparam int SQ_REM_W = SQ_STEPS + 2;
  localparam int NORM_MAX = WF / 2;

  // pipeline shape
  localparam int FRONT_STAGES = 10;
  localparam int BACK_STAGES  = 3;
  localparam int LATENCY      = DIV_STEPS + FRONT_STAGES + SQ_STEPS + BACK_STAGES + 1;

  // saturation bound and unit of the internal format
  localparam logic signed [63:0] SATW = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ONEW = 64'sh0000_0000_4000_0000;

  localparam int COMP_MAX = (1 << (COMP_BITS - 1)) - 1;
  localparam int COMP_MIN = -(1 << (COMP_BITS - 1));

  // one divider cell's view of a ray
  typedef struct packed {
    logic [INDEX_W-1:0] rem;
    logic [INDEX_W-1:0] num;
    logic [R_W-1:0]     quo;
    logic [INDEX_W-1:0] dsr;
  } div_t;

  // one square root cell's view of a ray
  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [SQ_STEPS-1:0] root;
    logic [SQ_X_W-1:0]   x;
  } sqrt_t;

  // ray data carried beside the divider
  typedef struct packed {
    logic                      bad;
    logic [2:0][COMP_BITS-1:0] d;
    logic [2:0][COMP_BITS-1:0] n;
  } side_t;

  // ray data carried through the arithmetic stages
  typedef struct packed {
    logic                      bad;
    logic                      tir;
    logic [2:0][COMP_BITS-1:0] d;
    logic [2:0][COMP_BITS-1:0] n;
    logic [R_W-1:0]            r;
    logic [45:0]               rhh;
    logic [45:0]               rhl;
    logic [45:0]               rll;
    logic [2:0][31:0]          p;
    logic [32:0]               ps;
    logic [61:0]               rr;
    logic [63:0]               sq;
    logic [58:0]               rch;
    logic [58:0]               rcl;
    logic [39:0]               cm1;
    logic [52:0]               rc;
    logic [2:0][39:0]          rdh;
    logic [2:0][39:0]          rdl;
    logic [2:0][48:0]          pn;
    logic [52:0]               t11;
    logic [49:0]               t10;
    logic [52:0]               t01;
    logic [49:0]               t00;
    logic [2:0][49:0]          rd;
    logic [2:0][39:0]          tres;
    logic [73:0]               tsh;
    logic [63:0]               t;
    logic [63:0]               rad;
    logic [3:0]                kh;
    logic [SQ_X_W-1:0]         x;
    logic [53:0]               beta;
    logic [2:0][42:0]          bnh;
    logic [2:0][43:0]          bnl;
    logic [2:0][55:0]          res;
  } ray_t;

endpackage

// ===== hw/rtl/vr3d_div_cell.sv =====
// one restoring division step of the index ratio
`timescale 1ns / 1ps

module vr3d_div_cell (
  input  logic           clk,
  input  logic           en,
  input  vr3d_pkg::div_t din,
  output vr3d_pkg::div_t dout
);

  vr3d_pkg::div_t             dout_r;
  vr3d_pkg::div_t             dout_nxt;
  logic [vr3d_pkg::INDEX_W:0] rem2;
  logic                       ge;

  // shift in one numerator bit, subtract the divisor when it fits
  always_comb begin
    rem2 = {din.rem, din.num[vr3d_pkg::INDEX_W-1]};
    ge   = rem2 >= {1'b0, din.dsr};
    dout_nxt.dsr = din.dsr;
    dout_nxt.num = {din.num[vr3d_pkg::INDEX_W-2:0], 1'b0};
    dout_nxt.quo = {din.quo[vr3d_pkg::R_W-2:0], ge};
    if (ge) begin
      dout_nxt.rem = vr3d_pkg::INDEX_W'(rem2 - {1'b0, din.dsr});
    end else begin
      dout_nxt.rem = vr3d_pkg::INDEX_W'(rem2);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule

// ===== hw/rtl/vr3d_sqrt_cell.sv =====
// one digit step of the integer square root
`timescale 1ns / 1ps

module vr3d_sqrt_cell (
  input  logic            clk,
  input  logic            en,
  input  vr3d_pkg::sqrt_t din,
  output vr3d_pkg::sqrt_t dout
);

  vr3d_pkg::sqrt_t              dout_r;
  vr3d_pkg::sqrt_t              dout_nxt;
  logic [vr3d_pkg::SQ_REM_W+1:0] rem2;
  logic [vr3d_pkg::SQ_REM_W+1:0] trial;
  logic                          ge;

  // bring down two radicand bits, try root*4+1
  always_comb begin
    rem2  = {din.rem, din.x[vr3d_pkg::SQ_X_W-1 -: 2]};
    trial = (vr3d_pkg::SQ_REM_W+2)'({din.root, 2'b01});
    ge    = rem2 >= trial;
    dout_nxt.x    = {din.x[vr3d_pkg::SQ_X_W-3:0], 2'b00};
    dout_nxt.root = {din.root[vr3d_pkg::SQ_STEPS-2:0], ge};
    if (ge) begin
      dout_nxt.rem = vr3d_pkg::SQ_REM_W'(rem2 - trial);
    end else begin
      dout_nxt.rem = vr3d_pkg::SQ_REM_W'(rem2);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule

// ===== hw/rtl/vector_refraction_3d_core.sv =====
// top level of the 3d vector refraction core
`timescale 1ns / 1ps

// Refracts one ray direction at a surface per transfer by the vector form of
// Snell's law, or reflects it on total internal reflection, with Q2.14
// components and Q4.12 indices. The core is fully pipelined: it takes one ray
// every cycle while no finished result is held, and presents each result on
// the output through 91 register stages. The depth is set by the index ratio
// divider, a row of 46 cells that each resolve one quotient bit, and the square
// root, a row of 31 cells that each resolve one root bit, plus 14 arithmetic
// and output stages. The whole pipeline holds while a finished result waits on
// out_ready, so in_ready follows out_ready whenever a result is pending.

module vector_refraction_3d_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_dir_x,
  input  logic [15:0] in_dir_y,
  input  logic [15:0] in_dir_z,
  input  logic [15:0] in_norm_x,
  input  logic [15:0] in_norm_y,
  input  logic [15:0] in_norm_z,
  input  logic [15:0] in_index_from,
  input  logic [15:0] in_index_to,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_res_x,
  output logic [15:0] out_res_y,
  output logic [15:0] out_res_z,
  output logic        out_total_reflect,
  output logic        out_bad_index,
  output logic        out_clipped
);

  localparam int DS = vr3d_pkg::DIV_STEPS;
  localparam int SS = vr3d_pkg::SQ_STEPS;
  localparam int FS = vr3d_pkg::FRONT_STAGES;
  localparam int BS = vr3d_pkg::BACK_STAGES;
  localparam int LT = vr3d_pkg::LATENCY;
  localparam int RS = vr3d_pkg::R_SPLIT;
  localparam int RH = vr3d_pkg::R_W - 1;
  localparam int CB = vr3d_pkg::COMP_BITS;

  logic                  en;
  logic [LT-1:0]         vld_r;
  vr3d_pkg::div_t        div_in  [DS];
  vr3d_pkg::div_t        div_out [DS];
  vr3d_pkg::sqrt_t       sq_in   [SS];
  vr3d_pkg::sqrt_t       sq_out  [SS];
  vr3d_pkg::side_t       side_r  [DS];
  vr3d_pkg::side_t       side_nxt;
  vr3d_pkg::ray_t        fa_r    [FS];
  vr3d_pkg::ray_t        fa_nxt  [FS];
  vr3d_pkg::ray_t        sqside_r[SS];
  vr3d_pkg::ray_t        ba_r    [BS];
  vr3d_pkg::ray_t        ba_nxt  [BS];
  logic [2:0][CB-1:0]    res_r;
  logic [2:0][CB-1:0]    res_nxt;
  logic                  tir_r, tir_nxt;
  logic                  bad_r, bad_nxt;
  logic                  clip_r, clip_nxt;

  // the pipeline moves unless a finished result is held
  assign en       = ~vld_r[LT-1] | out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LT-2:0], in_valid};
    end
  end

  // ratio divider row
  for (genvar k = 0; k < DS; k++) begin : g_div
    if (k == 0) begin : g_first
      assign div_in[k] = '{rem: '0, num: in_index_from, quo: '0, dsr: in_index_to};
    end else begin : g_next
      assign div_in[k] = div_out[k-1];
    end
    vr3d_div_cell u_cell (
      .clk  (clk),
      .en   (en),
      .din  (div_in[k]),
      .dout (div_out[k])
    );
  end

  // ray data travels beside the divider
  always_comb begin
    side_nxt.bad = (in_index_to == '0);
    side_nxt.d   = {in_dir_z, in_dir_y, in_dir_x};
    side_nxt.n   = {in_norm_z, in_norm_y, in_norm_x};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int k = 1; k < DS; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // square root row
  for (genvar k = 0; k < SS; k++) begin : g_sqrt
    if (k == 0) begin : g_first
      assign sq_in[k] = '{rem: '0, root: '0, x: fa_r[FS-1].x};
    end else begin : g_next
      assign sq_in[k] = sq_out[k-1];
    end
    vr3d_sqrt_cell u_cell (
      .clk  (clk),
      .en   (en),
      .din  (sq_in[k]),
      .dout (sq_out[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqside_r[0] <= fa_r[FS-1];
      for (int k = 1; k < SS; k++) begin
        sqside_r[k] <= sqside_r[k-1];
      end
    end
  end

  // arithmetic stages
  always_comb begin
    vr3d_pkg::ray_t        w;
    logic [91:0]           r2;
    logic signed [34:0]    cval;
    logic [31:0]           pm;
    logic signed [81:0]    rcx;
    logic signed [63:0]    rdx;
    logic signed [103:0]   tsum;
    logic signed [64:0]    rs;
    logic [61:0]           u;
    logic [45:0]           s;
    logic signed [71:0]    bnx;
    logic signed [55:0]    v;
    logic signed [39:0]    q;

    // dot product terms and r squared partials
    w       = '0;
    w.bad   = side_r[DS-1].bad;
    w.d     = side_r[DS-1].d;
    w.n     = side_r[DS-1].n;
    w.r     = div_out[DS-1].quo;
    for (int i = 0; i < 3; i++) begin
      w.p[i] = 32'($signed(w.d[i]) * $signed(w.n[i]));
    end
    w.rhh = 46'(w.r[RH:RS]) * 46'(w.r[RH:RS]);
    w.rhl = 46'(w.r[RH:RS]) * 46'(w.r[RS-1:0]);
    w.rll = 46'(w.r[RS-1:0]) * 46'(w.r[RS-1:0]);
    fa_nxt[0] = w;

    // dot product sum and r squared
    w    = fa_r[0];
    w.ps = 33'($signed(w.p[0])) + 33'($signed(w.p[1])) + 33'($signed(w.p[2]));
    r2   = {w.rhh, 46'b0} + (92'(w.rhl) << (RS + 1)) + 92'(w.rll);
    w.rr = r2[91:vr3d_pkg::WF];
    fa_nxt[1] = w;

    // c squared and r times c partials
    w    = fa_r[1];
    cval = -$signed({w.ps, 2'b00});
    if (w.ps[32]) begin
      pm = 32'(-$signed(w.ps));
    end else begin
      pm = w.ps[31:0];
    end
    w.sq  = 64'(pm) * 64'(pm);
    w.rch = 59'($signed({1'b0, w.r[RH:RS]}) * cval);
    w.rcl = 59'($signed({1'b0, w.r[RS-1:0]}) * cval);
    fa_nxt[2] = w;

    // c squared minus one, r times c, r times d partials, tir terms
    w     = fa_r[2];
    w.cm1 = 40'($signed({2'b00, w.sq[63:26]})) - 40'(vr3d_pkg::ONEW);
    rcx   = (82'($signed(w.rch)) <<< RS) + 82'($signed(w.rcl));
    w.rc  = 53'(rcx >>> vr3d_pkg::WF);
    for (int i = 0; i < 3; i++) begin
      w.rdh[i] = 40'($signed({1'b0, w.r[RH:RS]}) * $signed(w.d[i]));
      w.rdl[i] = 40'($signed({1'b0, w.r[RS-1:0]}) * $signed(w.d[i]));
      w.pn[i]  = 49'($signed(w.ps) * $signed(w.n[i]));
    end
    fa_nxt[3] = w;

    // radical product partials, r times d, reflected direction
    w     = fa_r[3];
    w.t11 = 53'($signed({1'b0, w.rr[61:31]}) * $signed(w.cm1[39:19]));
    w.t10 = 50'(w.rr[61:31]) * 50'(w.cm1[18:0]);
    w.t01 = 53'($signed({1'b0, w.rr[30:0]}) * $signed(w.cm1[39:19]));
    w.t00 = 50'(w.rr[30:0]) * 50'(w.cm1[18:0]);
    for (int i = 0; i < 3; i++) begin
      rdx       = (64'($signed(w.rdh[i])) <<< RS) + 64'($signed(w.rdl[i]));
      w.rd[i]   = 50'(rdx >>> vr3d_pkg::COMP_FRAC);
      w.tres[i] = (40'($signed(w.d[i])) <<< vr3d_pkg::OUT_SH) -
                  40'($signed(w.pn[i]) >>> 11);
    end
    fa_nxt[4] = w;

    // radical product sum
    w     = fa_r[4];
    tsum  = (104'($signed(w.t11)) <<< 50) + (104'(w.t10) << 31) +
            (104'($signed(w.t01)) <<< 19) + 104'(w.t00);
    w.tsh = 74'(tsum >>> vr3d_pkg::WF);
    fa_nxt[5] = w;

    // saturate the radical product
    w = fa_r[5];
    if ($signed(w.tsh) > 74'(vr3d_pkg::SATW)) begin
      w.t = vr3d_pkg::SATW;
    end else if ($signed(w.tsh) < -74'(vr3d_pkg::SATW)) begin
      w.t = -vr3d_pkg::SATW;
    end else begin
      w.t = w.tsh[63:0];
    end
    fa_nxt[6] = w;

    // radical and total internal reflection
    w  = fa_r[6];
    rs = 65'($signed(w.t)) + 65'(vr3d_pkg::ONEW);
    if (rs > 65'(vr3d_pkg::SATW)) begin
      w.rad = vr3d_pkg::SATW;
    end else begin
      w.rad = rs[63:0];
    end
    w.tir = w.rad[63];
    fa_nxt[7] = w;

    // normalizing shift for the root
    w = fa_r[7];
    if (w.tir) begin
      u = '0;
    end else begin
      u = w.rad[61:0];
    end
    w.x  = u;
    w.kh = '0;
    for (int j = 1; j <= vr3d_pkg::NORM_MAX; j++) begin
      if ((u >> (vr3d_pkg::SQ_X_W - 2 * j)) == '0) begin
        w.kh = 4'(j);
      end
    end
    fa_nxt[8] = w;

    // normalize the radicand
    w   = fa_r[8];
    w.x = vr3d_pkg::SQ_X_W'(w.x << {w.kh, 1'b0});
    fa_nxt[9] = w;

    // denormalize the root and form beta
    w      = sqside_r[SS-1];
    s      = 46'(46'(sq_out[SS-1].root) << (4'(vr3d_pkg::NORM_MAX) - w.kh));
    w.beta = 54'($signed(w.rc)) - 54'($signed({1'b0, s}));
    ba_nxt[0] = w;

    // beta times normal partials
    w = ba_r[0];
    for (int i = 0; i < 3; i++) begin
      w.bnh[i] = 43'($signed(w.beta[53:27]) * $signed(w.n[i]));
      w.bnl[i] = 44'($signed({1'b0, w.beta[26:0]}) * $signed(w.n[i]));
    end
    ba_nxt[1] = w;

    // refracted direction
    w = ba_r[1];
    for (int i = 0; i < 3; i++) begin
      bnx      = (72'($signed(w.bnh[i])) <<< 27) + 72'($signed(w.bnl[i]));
      w.res[i] = 56'(72'($signed(w.rd[i])) + (bnx >>> vr3d_pkg::COMP_FRAC));
    end
    ba_nxt[2] = w;

    // convert back to components and saturate
    w        = ba_r[2];
    clip_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (w.tir) begin
        v = 56'($signed(w.tres[i]));
      end else begin
        v = $signed(w.res[i]);
      end
      q = 40'(v >>> vr3d_pkg::OUT_SH);
      if (q > 40'(vr3d_pkg::COMP_MAX)) begin
        res_nxt[i] = CB'(vr3d_pkg::COMP_MAX);
        clip_nxt   = 1'b1;
      end else if (q < 40'(vr3d_pkg::COMP_MIN)) begin
        res_nxt[i] = CB'(vr3d_pkg::COMP_MIN);
        clip_nxt   = 1'b1;
      end else begin
        res_nxt[i] = q[CB-1:0];
      end
    end
    tir_nxt = w.tir;
    bad_nxt = w.bad;
    // zero destination index passes the direction through
    if (w.bad) begin
      res_nxt  = w.d;
      tir_nxt  = 1'b0;
      clip_nxt = 1'b0;
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < FS; k++) begin
        fa_r[k] <= fa_nxt[k];
      end
      ba_r[0] <= ba_nxt[0];
      ba_r[1] <= ba_nxt[1];
      ba_r[2] <= ba_nxt[2];
      res_r   <= res_nxt;
      tir_r   <= tir_nxt;
      bad_r   <= bad_nxt;
      clip_r  <= clip_nxt;
    end
  end

  assign out_valid         = vld_r[LT-1];
  assign out_res_x         = res_r[0];
  assign out_res_y         = res_r[1];
  assign out_res_z         = res_r[2];
  assign out_total_reflect = tir_r;
  assign out_bad_index     = bad_r;
  assign out_clipped       = clip_r;

endmodule

// ===== hw/rtl/vr3d_checker.sv =====
// port level checks of the 3d refraction core and their binding
`timescale 1ns / 1ps

module vr3d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [15:0] in_dir_x,
  input logic [15:0] in_dir_y,
  input logic [15:0] in_dir_z,
  input logic [15:0] in_norm_x,
  input logic [15:0] in_norm_y,
  input logic [15:0] in_norm_z,
  input logic [15:0] in_index_from,
  input logic [15:0] in_index_to,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_res_x,
  input logic [15:0] out_res_y,
  input logic [15:0] out_res_z,
  input logic        out_total_reflect,
  input logic        out_bad_index,
  input logic        out_clipped
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a bad index result is a plain pass-through
  a_bad_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_index |-> !out_total_reflect && !out_clipped)
    else $error("bad index result carries other flags");

  // the core takes rays whenever no result is pending
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no pending result");

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res_x) &&
      $stable(out_res_y) && $stable(out_res_z) && $stable(out_clipped))
    else $error("held result changed");

  // an offered ray stays put until its transfer
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_dir_x) && $stable(in_dir_y) &&
      $stable(in_dir_z) && $stable(in_norm_x) && $stable(in_norm_y) &&
      $stable(in_norm_z) && $stable(in_index_from) && $stable(in_index_to))
    else $error("offered ray changed before transfer");

endmodule

bind vector_refraction_3d_core vr3d_checker u_vr3d_checker (.*);

// ===== dv/vr3d_checker.sv =====
// scoreboard for the 3d refraction core: predicts each ray and compares results
`timescale 1ns / 1ps

module vr3d_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] in_dir_x,
  input  logic [15:0] in_dir_y,
  input  logic [15:0] in_dir_z,
  input  logic [15:0] in_norm_x,
  input  logic [15:0] in_norm_y,
  input  logic [15:0] in_norm_z,
  input  logic [15:0] in_index_from,
  input  logic [15:0] in_index_to,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_res_x,
  input  logic [15:0] out_res_y,
  input  logic [15:0] out_res_z,
  input  logic        out_total_reflect,
  input  logic        out_bad_index,
  input  logic        out_clipped,
  output int          fail_count,
  output int          rays_in_flight
);

  typedef logic signed [63:0] fx_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        tir;
    logic        bad;
    logic        clip;
  } ray_out_t;

  ray_out_t expected_rays[$];

  // saturate to the internal range
  function automatic fx_t sat_fx(input logic signed [127:0] v);
    logic signed [127:0] hi;
    hi = vr3d_pkg::SATW;
    if (v > hi) return vr3d_pkg::SATW;
    if (v < -hi) return -vr3d_pkg::SATW;
    return fx_t'(v);
  endfunction

  function automatic fx_t add_fx(input fx_t a, input fx_t b);
    logic signed [127:0] wa, wb;
    wa = a;
    wb = b;
    return sat_fx(wa + wb);
  endfunction

  // exact product, floor shift by the fraction width, then saturate
  function automatic fx_t mul_fx(input fx_t a, input fx_t b);
    logic signed [127:0] wa, wb, p;
    wa = a;
    wb = b;
    p = wa * wb;
    return sat_fx(p >>> vr3d_pkg::WF);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // normalize by an even shift, take the root, then scale back
  function automatic fx_t sqrt_fx(input fx_t rad);
    int k;
    logic [63:0] u;
    k = vr3d_pkg::WF;
    u = rad;
    while (k > 0 && u > (((64'd1 << 62) - 64'd1) >> k)) k -= 2;
    return fx_t'(floor_sqrt(u << k) << ((vr3d_pkg::WF - k) / 2));
  endfunction

  function automatic fx_t widen_comp(input logic [15:0] raw);
    fx_t v;
    v = fx_t'($signed(raw));
    return v <<< (vr3d_pkg::WF - vr3d_pkg::COMP_FRAC);
  endfunction

  function automatic logic [15:0] narrow_comp(input fx_t v, inout logic clip);
    fx_t q;
    q = v >>> vr3d_pkg::OUT_SH;
    if (q > vr3d_pkg::COMP_MAX) begin
      q = fx_t'(vr3d_pkg::COMP_MAX);
      clip = 1'b1;
    end
    if (q < vr3d_pkg::COMP_MIN) begin
      q = fx_t'(vr3d_pkg::COMP_MIN);
      clip = 1'b1;
    end
    return q[15:0];
  endfunction

  // refracted or reflected direction for one ray
  function automatic ray_out_t refract_ray(input logic [15:0] dr[3], input logic [15:0] nr[3],
                                           input logic [15:0] src, input logic [15:0] dst);
    ray_out_t o;
    fx_t d[3], n[3], dn, c, r, rad, s, beta, two_dn, res[3];
    logic [63:0] num;
    logic clip;
    clip = 1'b0;
    o.tir = 1'b0;
    o.bad = 1'b0;
    // zero destination index passes the direction through
    if (dst == 0) begin
      o.x = dr[0];
      o.y = dr[1];
      o.z = dr[2];
      o.bad = 1'b1;
      o.clip = 1'b0;
      return o;
    end
    for (int i = 0; i < 3; i++) begin
      d[i] = widen_comp(dr[i]);
      n[i] = widen_comp(nr[i]);
    end
    dn = add_fx(add_fx(mul_fx(d[0], n[0]), mul_fx(d[1], n[1])), mul_fx(d[2], n[2]));
    c = -dn;
    num = {48'd0, src} << vr3d_pkg::WF;
    r = fx_t'(num / {48'd0, dst});
    rad = add_fx(vr3d_pkg::ONEW,
                 mul_fx(mul_fx(r, r), add_fx(mul_fx(c, c), -vr3d_pkg::ONEW)));
    if (rad < 0) begin
      two_dn = add_fx(dn, dn);
      o.tir = 1'b1;
      for (int i = 0; i < 3; i++) res[i] = add_fx(d[i], -mul_fx(two_dn, n[i]));
    end else begin
      s = sqrt_fx(rad);
      beta = add_fx(mul_fx(r, c), -s);
      for (int i = 0; i < 3; i++) res[i] = add_fx(mul_fx(r, d[i]), mul_fx(beta, n[i]));
    end
    o.x = narrow_comp(res[0], clip);
    o.y = narrow_comp(res[1], clip);
    o.z = narrow_comp(res[2], clip);
    o.clip = clip;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // predict on each input transfer, compare on each result transfer
  always @(posedge clk) begin
    ray_out_t want;
    logic [15:0] dr[3], nr[3];
    if (rst_n && in_valid && in_ready) begin
      dr[0] = in_dir_x;  dr[1] = in_dir_y;  dr[2] = in_dir_z;
      nr[0] = in_norm_x; nr[1] = in_norm_y; nr[2] = in_norm_z;
      expected_rays.push_back(refract_ray(dr, nr, in_index_from, in_index_to));
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_rays.size() == 0) begin
        report_mismatch("unexpected result transfer", out_res_x, 16'h0000);
      end else begin
        want = expected_rays.pop_front();
        if (out_res_x !== want.x) report_mismatch("res_x", out_res_x, want.x);
        if (out_res_y !== want.y) report_mismatch("res_y", out_res_y, want.y);
        if (out_res_z !== want.z) report_mismatch("res_z", out_res_z, want.z);
        if (out_total_reflect !== want.tir)
          report_mismatch("total_reflect", 16'(out_total_reflect), 16'(want.tir));
        if (out_bad_index !== want.bad)
          report_mismatch("bad_index", 16'(out_bad_index), 16'(want.bad));
        if (out_clipped !== want.clip)
          report_mismatch("clipped", 16'(out_clipped), 16'(want.clip));
      end
    end
    rays_in_flight = expected_rays.size();
  end

endmodule

// ===== dv/vector_refraction_3d_core_test.sv =====
// testbench top for the 3d refraction core: ray stimulus, back pressure and verdict
`timescale 1ns / 1ps

module vector_refraction_3d_core_test;

  localparam int RANDOM_RAYS = 530;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [15:0] ONE_C = 16'h4000;
  localparam logic [15:0] ONE_I = 16'h1000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [15:0] in_dir_x, in_dir_y, in_dir_z, in_norm_x, in_norm_y, in_norm_z;
  logic [15:0] in_index_from, in_index_to;
  logic [15:0] out_res_x, out_res_y, out_res_z;
  logic out_total_reflect, out_bad_index, out_clipped;
  int fail_count, rays_in_flight, cycle_count, rays_sent;
  logic hold_off_req;

  vector_refraction_3d_core dut (.*);
  vr3d_scoreboard scoreboard (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stalls, quiet stretches, and one long hold-off
  initial begin
    int mode_left, hold;
    logic quiet;
    out_ready = 1'b0;
    mode_left = 0;
    quiet = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req && hold == 0) hold = 300;
      if (mode_left == 0) begin
        mode_left = $urandom_range(10, 60);
        quiet = ($urandom_range(0, 3) == 0);
      end
      mode_left--;
      if (hold > 1) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet ? 1'b1 : ($urandom_range(0, 2) != 0);
      end
    end
  end

  // offer one ray and wait for its transfer
  task automatic send_ray(input logic [15:0] dx, dy, dz, nx, ny, nz, src, dst);
    in_dir_x <= dx;  in_dir_y <= dy;  in_dir_z <= dz;
    in_norm_x <= nx; in_norm_y <= ny; in_norm_z <= nz;
    in_index_from <= src;
    in_index_to <= dst;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rays_sent++;
  endtask

  function automatic logic [15:0] unit_axis();
    return ($urandom_range(0, 1) != 0) ? ONE_C : -ONE_C;
  endfunction

  initial begin
    int burst, kind, axis;
    logic [15:0] nv[3], dv[3], src, dst;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_dir_x = 0; in_dir_y = 0; in_dir_z = 0;
    in_norm_x = 0; in_norm_y = 0; in_norm_z = 0;
    in_index_from = 0; in_index_to = 0;
    rays_sent = 0;
    hold_off_req = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rays
    send_ray(0, 0, -ONE_C, 0, 0, ONE_C, ONE_I, ONE_I);
    send_ray(16'h2d41, 0, -16'h2d41, 0, 0, ONE_C, 16'h1800, 16'h1000);
    send_ray(16'h2d41, 0, -16'h2d41, 0, 0, ONE_C, 16'h1000, 16'h1800);
    send_ray(ONE_C, 0, 0, 0, 0, ONE_C, ONE_I, ONE_I);
    send_ray(16'h3000, 0, -16'h1000, 0, 0, ONE_C, 16'h4000, 16'h1000);
    send_ray(16'h1234, 16'h8000, 16'h7fff, 0, ONE_C, 0, 16'h1000, 0);
    send_ray(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff, 16'hffff);
    send_ray(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 16'h0001);
    send_ray(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff);
    send_ray(16'h8000, 16'h7fff, 0, 16'h7fff, 0, 16'h8000, 16'hffff, 16'h0001);
    send_ray(0, 0, 0, 0, 0, 0, 16'h0000, 16'h1000);
    send_ray(16'h2000, 16'h2000, 16'h2000, 16'h1000, 16'h1000, 16'h1000, 16'h1a00, 16'h1000);
    send_ray(16'h7fff, 0, 0, ONE_C, 0, 0, 16'hffff, 16'h0001);
    send_ray(0, 16'h2000, -16'h3000, 0, -ONE_C, 0, 16'h1555, 16'h2000);
    send_ray(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h0000, 16'hffff);
    in_valid <= 1'b0;
    @(posedge clk);

    // random rays in bursts; mostly axis normals and plausible indices
    while (rays_sent < RANDOM_RAYS + 15) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst; b++) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          axis = $urandom_range(0, 2);
          for (int i = 0; i < 3; i++) begin
            nv[i] = (i == axis) ? unit_axis() : 16'h0000;
            dv[i] = 16'($signed($urandom_range(0, 32768)) - 16384);
          end
          src = 16'($urandom_range(16'h0c00, 16'h2800));
          dst = 16'($urandom_range(16'h0c00, 16'h2800));
        end else begin
          for (int i = 0; i < 3; i++) begin
            nv[i] = 16'($urandom());
            dv[i] = 16'($urandom());
          end
          src = 16'($urandom());
          dst = (kind == 9 && $urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom());
        end
        send_ray(dv[0], dv[1], dv[2], nv[0], nv[1], nv[2], src, dst);
        if (rays_sent == 200) hold_off_req <= 1'b1;
        if (rays_sent == 210) hold_off_req <= 1'b0;
      end
      in_valid <= 1'b0;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 15)) @(posedge clk);
      else @(posedge clk);
    end
    in_valid <= 1'b0;
    hold_off_req <= 1'b0;

    // drain and let the pipeline settle
    while (rays_in_flight != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/vr3d_pkg.sv
hw/rtl/vr3d_div_cell.sv
hw/rtl/vr3d_sqrt_cell.sv
hw/rtl/vector_refraction_3d_core.sv
hw/rtl/vr3d_checker.sv
dv/vr3d_checker.sv
dv/vector_refraction_3d_core_test.sv
